[src/upp_pkg.sv]
// Shared types, constants and helper functions for the unicycle pose predictor.
package upp_pkg;

  localparam int POS_W = 32;
  localparam int DT_W  = 24;
  localparam int DV_W  = 56;
  localparam int ANG_W = 34;

  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_GAIN    = 64'd652032874;

  localparam logic [DT_W-1:0] STEP_TIME_RST = 24'd6554;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] heading;
    logic signed [POS_W-1:0] cmd_speed;
    logic signed [POS_W-1:0] cmd_turn_rate;
  } in_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_pos_x;
    logic signed [POS_W-1:0] new_pos_y;
    logic signed [POS_W-1:0] new_heading;
    logic signed [POS_W-1:0] new_speed;
  } out_res_t;

  // Side data that rides along the pipeline next to the angle path.
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] hd;
    logic signed [POS_W-1:0] v;
    logic signed [DV_W-1:0]  dv;
    logic signed [DV_W-1:0]  dw;
  } ride_t;

  // Arctangent of 2^-i in Q30; beyond the table the angle equals 2^-i.
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] res;
    case (i)
      0: res = 34'sd843314857;
      1: res = 34'sd497837829;
      2: res = 34'sd263043837;
      3: res = 34'sd133525159;
      4: res = 34'sd67021687;
      5: res = 34'sd33543516;
      6: res = 34'sd16775851;
      7: res = 34'sd8388437;
      8: res = 34'sd4194283;
      9: res = 34'sd2097149;
      default: res = ANG_W'(64'd1 << (30 - i));
    endcase
    return res;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [POS_W-1:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

[src/unicycle_pose_predict_top.sv]
// Unicycle pose predictor: fully pipelined angle reduction, CORDIC and position update.
// Throughput: one request per cycle; busy is always low since every stage advances each cycle.
// The modulo-2*pi reduction takes 29 - FRAC_BITS stages and the CORDIC one stage per iteration.
// Reset (rst_n low, synchronous) clears all valid bits and sets step_time to 6554.
module unicycle_pose_predict_top #(
  parameter int FRAC_BITS         = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  upp_pkg::in_req_t                   in_req,
  output logic                               out_valid,
  output upp_pkg::out_res_t                  out_res,
  input  logic                               cfg_we,
  input  logic [upp_pkg::DT_W-1:0]           cfg_wdata
);

  localparam int F   = FRAC_BITS;
  localparam int N   = CORDIC_ITERATIONS;
  localparam int MW  = 62 - F;   // width of the scaled heading magnitude
  localparam int RED = 29 - F;   // number of conditional subtract stages
  localparam int AW  = upp_pkg::ANG_W;
  localparam int DW  = upp_pkg::DV_W;
  localparam int LAT = 36 - F + N;

  localparam logic signed [AW-1:0] PI_S     = AW'(upp_pkg::Q30_PI);
  localparam logic signed [AW-1:0] TWO_PI_S = AW'(upp_pkg::Q30_TWO_PI);
  localparam logic signed [AW-1:0] HALF_S   = AW'(upp_pkg::Q30_HALF_PI);

  // The pipeline never stalls, so a new request is taken in every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Time step register. The user must write it only while no request is in flight; the block does not enforce it.
  logic [upp_pkg::DT_W-1:0] step_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= upp_pkg::STEP_TIME_RST;
    end else if (cfg_we) begin
      step_time_r <= cfg_wdata;
    end
  end

  // Stage 1: capture the request, form dt*v and dt*omega, and scale |heading| to Q30.
  logic                vld_red_r  [0:RED];
  logic [MW-1:0]       mag_red_r  [0:RED];
  logic                neg_red_r  [0:RED];
  upp_pkg::ride_t      ride_red_r [0:RED];

  logic signed [DW:0]  dv_full;
  logic signed [DW:0]  dw_full;
  logic [32:0]         hd_abs;
  upp_pkg::ride_t      ride_in;

  always_comb begin
    dv_full         = $signed({1'b0, step_time_r}) * in_req.cmd_speed;
    dw_full         = $signed({1'b0, step_time_r}) * in_req.cmd_turn_rate;
    hd_abs          = in_req.heading[31] ? 33'(-{in_req.heading[31], in_req.heading})
                                         : {1'b0, in_req.heading};
    ride_in.px      = in_req.pos_x;
    ride_in.py      = in_req.pos_y;
    ride_in.hd      = in_req.heading;
    ride_in.v       = in_req.cmd_speed;
    ride_in.dv      = dv_full[DW-1:0];
    ride_in.dw      = dw_full[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_red_r[0] <= 1'b0;
    end else begin
      vld_red_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    mag_red_r[0]  <= MW'(64'(hd_abs) << (30 - F));
    neg_red_r[0]  <= in_req.heading[31];
    ride_red_r[0] <= ride_in;
  end

  // Modulo 2*pi on the magnitude: stage k conditionally subtracts 2*pi*2^(RED-1-k),
  // from the largest multiple down. The sign is put back afterwards, which gives
  // a remainder that takes the sign of the heading.
  for (genvar k = 0; k < RED; k++) begin : g_red
    localparam logic [63:0] SUB = upp_pkg::Q30_TWO_PI << (RED - 1 - k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_red_r[k+1] <= 1'b0;
      end else begin
        vld_red_r[k+1] <= vld_red_r[k];
      end
    end

    always_ff @(posedge clk) begin
      mag_red_r[k+1]  <= (mag_red_r[k] >= SUB[MW-1:0]) ? mag_red_r[k] - SUB[MW-1:0]
                                                        : mag_red_r[k];
      neg_red_r[k+1]  <= neg_red_r[k];
      ride_red_r[k+1] <= ride_red_r[k];
    end
  end

  // Wrap stage: bring the signed remainder into [-pi, pi). The heading increment
  // dt*omega is rounded half away from zero in parallel.
  logic                 vld_wrap_r;
  logic signed [AW-1:0] ang_wrap_r;
  upp_pkg::ride_t       ride_wrap_r;

  logic signed [AW-1:0] rem_s;
  logic signed [AW-1:0] ang_wrap_nxt;
  logic [DW-1:0]        dw_mag;
  logic [DW-1:0]        dw_q;
  upp_pkg::ride_t       ride_wrap_nxt;

  always_comb begin
    rem_s = $signed({1'b0, mag_red_r[RED][AW-2:0]});
    if (!neg_red_r[RED]) begin
      ang_wrap_nxt = (rem_s >= PI_S) ? rem_s - TWO_PI_S : rem_s;
    end else begin
      ang_wrap_nxt = (rem_s > PI_S) ? TWO_PI_S - rem_s : -rem_s;
    end
    ride_wrap_nxt    = ride_red_r[RED];
    dw_mag           = ride_red_r[RED].dw[DW-1] ? DW'(-ride_red_r[RED].dw)
                                                : DW'(ride_red_r[RED].dw);
    dw_q             = (dw_mag + (DW'(1) << (F - 1))) >> F;
    ride_wrap_nxt.dw = ride_red_r[RED].dw[DW-1] ? -$signed(dw_q) : $signed(dw_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_wrap_r <= 1'b0;
    end else begin
      vld_wrap_r <= vld_red_r[RED];
    end
  end

  always_ff @(posedge clk) begin
    ang_wrap_r  <= ang_wrap_nxt;
    ride_wrap_r <= ride_wrap_nxt;
  end

  // Fold stage: angles beyond +-pi/2 move by pi and the final cos/sin are negated.
  // The new heading is completed here and replaces the old one in the side data.
  logic                 vld_cor_r  [0:N];
  logic signed [AW-1:0] x_cor_r    [0:N];
  logic signed [AW-1:0] y_cor_r    [0:N];
  logic signed [AW-1:0] z_cor_r    [0:N];
  logic                 flip_cor_r [0:N];
  upp_pkg::ride_t       ride_cor_r [0:N];

  logic signed [AW-1:0] z_fold;
  logic                 flip_fold;
  upp_pkg::ride_t       ride_fold;

  always_comb begin
    flip_fold = 1'b0;
    z_fold    = ang_wrap_r;
    if (ang_wrap_r > HALF_S) begin
      z_fold    = ang_wrap_r - PI_S;
      flip_fold = 1'b1;
    end else if (ang_wrap_r < -HALF_S) begin
      z_fold    = ang_wrap_r + PI_S;
      flip_fold = 1'b1;
    end
    ride_fold    = ride_wrap_r;
    ride_fold.hd = upp_pkg::sat32(64'(ride_wrap_r.hd) + 64'(ride_wrap_r.dw));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_cor_r[0] <= 1'b0;
    end else begin
      vld_cor_r[0] <= vld_wrap_r;
    end
  end

  always_ff @(posedge clk) begin
    x_cor_r[0]    <= AW'(upp_pkg::Q30_GAIN);
    y_cor_r[0]    <= '0;
    z_cor_r[0]    <= z_fold;
    flip_cor_r[0] <= flip_fold;
    ride_cor_r[0] <= ride_fold;
  end

  // CORDIC rotation, one iteration per stage.
  for (genvar i = 0; i < N; i++) begin : g_cor
    localparam logic signed [AW-1:0] STEP = upp_pkg::atan_step(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_cor_r[i+1] <= 1'b0;
      end else begin
        vld_cor_r[i+1] <= vld_cor_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!z_cor_r[i][AW-1]) begin
        x_cor_r[i+1] <= x_cor_r[i] - (y_cor_r[i] >>> i);
        y_cor_r[i+1] <= y_cor_r[i] + (x_cor_r[i] >>> i);
        z_cor_r[i+1] <= z_cor_r[i] - STEP;
      end else begin
        x_cor_r[i+1] <= x_cor_r[i] + (y_cor_r[i] >>> i);
        y_cor_r[i+1] <= y_cor_r[i] - (x_cor_r[i] >>> i);
        z_cor_r[i+1] <= z_cor_r[i] + STEP;
      end
      flip_cor_r[i+1] <= flip_cor_r[i];
      ride_cor_r[i+1] <= ride_cor_r[i];
    end
  end

  // Magnitude stage: split the factors into sign and magnitude and form each product's sign.
  logic              vld_abs_r;
  logic [31:0]       cm_r;
  logic [31:0]       sm_r;
  logic [DW-1:0]     dvm_r;
  logic              nx_abs_r;
  logic              ny_abs_r;
  upp_pkg::ride_t    ride_abs_r;

  logic signed [AW-1:0] xf;
  logic signed [AW-1:0] yf;
  logic signed [DW-1:0] dvf;

  always_comb begin
    xf  = x_cor_r[N];
    yf  = y_cor_r[N];
    dvf = ride_cor_r[N].dv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_abs_r <= 1'b0;
    end else begin
      vld_abs_r <= vld_cor_r[N];
    end
  end

  always_ff @(posedge clk) begin
    cm_r       <= xf[AW-1] ? 32'(-xf) : 32'(xf);
    sm_r       <= yf[AW-1] ? 32'(-yf) : 32'(yf);
    dvm_r      <= dvf[DW-1] ? DW'(-dvf) : DW'(dvf);
    nx_abs_r   <= dvf[DW-1] ^ flip_cor_r[N] ^ xf[AW-1];
    ny_abs_r   <= dvf[DW-1] ^ flip_cor_r[N] ^ yf[AW-1];
    ride_abs_r <= ride_cor_r[N];
  end

  // Multiply stage: |dt*v| is cut into a low 32-bit and a high 24-bit part.
  logic              vld_mul_r;
  logic [63:0]       plx_r;
  logic [55:0]       phx_r;
  logic [63:0]       ply_r;
  logic [55:0]       phy_r;
  logic              nx_mul_r;
  logic              ny_mul_r;
  upp_pkg::ride_t    ride_mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_mul_r <= 1'b0;
    end else begin
      vld_mul_r <= vld_abs_r;
    end
  end

  always_ff @(posedge clk) begin
    plx_r      <= 64'(dvm_r[31:0]) * 64'(cm_r);
    phx_r      <= 56'(dvm_r[DW-1:32]) * 56'(cm_r);
    ply_r      <= 64'(dvm_r[31:0]) * 64'(sm_r);
    phy_r      <= 56'(dvm_r[DW-1:32]) * 56'(sm_r);
    nx_mul_r   <= nx_abs_r;
    ny_mul_r   <= ny_abs_r;
    ride_mul_r <= ride_abs_r;
  end

  // Rounding stage: combine partial products, round half away from zero, drop 2^(F+30).
  logic              vld_rnd_r;
  logic signed [63:0] qx_r;
  logic signed [63:0] qy_r;
  upp_pkg::ride_t    ride_rnd_r;

  logic [87:0] sum_x;
  logic [87:0] sum_y;
  logic [63:0] mag_x;
  logic [63:0] mag_y;

  always_comb begin
    sum_x = (88'(phx_r) << 32) + 88'(plx_r) + (88'(1) << (F + 29));
    sum_y = (88'(phy_r) << 32) + 88'(ply_r) + (88'(1) << (F + 29));
    mag_x = 64'(sum_x >> (F + 30));
    mag_y = 64'(sum_y >> (F + 30));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_rnd_r <= 1'b0;
    end else begin
      vld_rnd_r <= vld_mul_r;
    end
  end

  always_ff @(posedge clk) begin
    qx_r       <= nx_mul_r ? -$signed(mag_x) : $signed(mag_x);
    qy_r       <= ny_mul_r ? -$signed(mag_y) : $signed(mag_y);
    ride_rnd_r <= ride_mul_r;
  end

  // Output stage: add to the old position and saturate.
  logic              out_valid_r;
  upp_pkg::out_res_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_rnd_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r.new_pos_x   <= upp_pkg::sat32(64'(ride_rnd_r.px) + qx_r);
    out_res_r.new_pos_y   <= upp_pkg::sat32(64'(ride_rnd_r.py) + qy_r);
    out_res_r.new_heading <= ride_rnd_r.hd;
    out_res_r.new_speed   <= ride_rnd_r.v;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Every result strobe goes back to exactly one accepted request.
  a_strobe_matches_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

  // The reduced magnitude is always below 2*pi.
  a_reduce_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_red_r[RED] |-> (mag_red_r[RED] < MW'(upp_pkg::Q30_TWO_PI)))
    else $error("angle reduction left a remainder of 2*pi or more");

  // The folded angle fed to the CORDIC lies within +-pi/2.
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_cor_r[0] |-> (z_cor_r[0] <= HALF_S) && (z_cor_r[0] >= -HALF_S))
    else $error("CORDIC input angle outside +-pi/2");

  // The pipeline is never blocked.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("request refused");

endmodule

[tb/unicycle_pose_predict_top_test.sv]
// Self-checking testbench for the unicycle pose predictor with a built-in fixed-point predictor.
`timescale 1ns / 100ps

module unicycle_pose_predict_top_test;

  localparam int FRAC       = 16;
  localparam int ITERS      = 16;
  // Wait for the pipeline to drain; longer than the pipeline is deep.
  localparam int DRAIN_WAIT = 48;
  localparam longint PI_Q30      = longint'(upp_pkg::Q30_PI);
  localparam longint TWO_PI_Q30  = longint'(upp_pkg::Q30_TWO_PI);
  localparam longint HALF_PI_Q30 = longint'(upp_pkg::Q30_HALF_PI);
  localparam longint GAIN_Q30    = longint'(upp_pkg::Q30_GAIN);
  // Q16.16 values of pi and pi/2, used to aim headings at the quadrant edges.
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  upp_pkg::in_req_t in_req;
  logic out_valid;
  upp_pkg::out_res_t out_res;
  logic cfg_we;
  logic [upp_pkg::DT_W-1:0] cfg_wdata;

  // The predictor's own copy of the time step register.
  logic [upp_pkg::DT_W-1:0] dt_shadow;
  // Predicted poses, oldest first, waiting for their result strobes.
  upp_pkg::out_res_t pending_poses[$];
  int fail_count;

  unicycle_pose_predict_top #(
    .FRAC_BITS(FRAC),
    .CORDIC_ITERATIONS(ITERS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Arctangent of 2^-i in Q30; a table for the first ten micro-rotations, then 2^-i.
  function automatic longint arctan_q30(input int i);
    longint a;
    case (i)
      0: a = 843314857;
      1: a = 497837829;
      2: a = 263043837;
      3: a = 133525159;
      4: a = 67021687;
      5: a = 33543516;
      6: a = 16775851;
      7: a = 8388437;
      8: a = 4194283;
      9: a = 2097149;
      default: a = longint'(1) << (30 - i);
    endcase
    return a;
  endfunction

  function automatic longint clamp32(input longint v);
    longint r;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Rounds p * t / 2^(F+30) half away from zero, using a wide product.
  function automatic longint scale_by_trig(input longint p, input longint t);
    logic neg;
    logic [127:0] m;
    logic [127:0] c;
    logic [127:0] q;
    neg = (p < 0) != (t < 0);
    m = (p < 0) ? 128'(-p) : 128'(p);
    c = (t < 0) ? 128'(-t) : 128'(t);
    q = (m * c + (128'd1 << (FRAC + 29))) >> (FRAC + 30);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_off_frac(input longint p);
    longint unsigned m;
    longint unsigned q;
    m = (p < 0) ? longint'(-p) : p;
    q = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic upp_pkg::out_res_t predict_pose(input upp_pkg::in_req_t r,
                                                     input logic [upp_pkg::DT_W-1:0] dt);
    upp_pkg::out_res_t res;
    longint ang;
    longint cx;
    longint sy;
    longint z;
    longint dx;
    longint dy;
    longint dv;
    longint dt_l;
    logic mirrored;
    // Reduce the heading into [-pi, pi), then fold it into [-pi/2, pi/2].
    ang = (longint'(r.heading) * (longint'(1) << (30 - FRAC))) % TWO_PI_Q30;
    if (ang >= PI_Q30) ang = ang - TWO_PI_Q30;
    if (ang < -PI_Q30) ang = ang + TWO_PI_Q30;
    mirrored = 1'b0;
    if (ang > HALF_PI_Q30) begin
      ang = ang - PI_Q30;
      mirrored = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      ang = ang + PI_Q30;
      mirrored = 1'b1;
    end
    cx = GAIN_Q30;
    sy = 0;
    z = ang;
    for (int i = 0; i < ITERS; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        sy = sy + dy;
        z = z - arctan_q30(i);
      end else begin
        cx = cx + dx;
        sy = sy - dy;
        z = z + arctan_q30(i);
      end
    end
    if (mirrored) begin
      cx = -cx;
      sy = -sy;
    end
    dt_l = longint'({40'd0, dt});
    dv = dt_l * longint'(r.cmd_speed);
    res.new_pos_x   = 32'(clamp32(longint'(r.pos_x) + scale_by_trig(dv, cx)));
    res.new_pos_y   = 32'(clamp32(longint'(r.pos_y) + scale_by_trig(dv, sy)));
    res.new_heading = 32'(clamp32(longint'(r.heading) +
                                  round_off_frac(dt_l * longint'(r.cmd_turn_rate))));
    res.new_speed   = r.cmd_speed;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
  endtask

  // Every strobe is checked against the oldest predicted pose.
  always @(posedge clk) begin
    upp_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected result", out_res.new_pos_x, 32'd0);
      end else begin
        want = pending_poses.pop_front();
        if (out_res.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", out_res.new_pos_x, want.new_pos_x);
        if (out_res.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", out_res.new_pos_y, want.new_pos_y);
        if (out_res.new_heading !== want.new_heading)
          report_mismatch("new_heading", out_res.new_heading, want.new_heading);
        if (out_res.new_speed !== want.new_speed)
          report_mismatch("new_speed", out_res.new_speed, want.new_speed);
      end
    end
  end

  // Presents one request and holds it until the block takes it. The start line stays
  // high afterwards so that back-to-back requests keep it asserted.
  task automatic send_request(input upp_pkg::in_req_t r);
    logic taken;
    @(negedge clk);
    start = 1'b1;
    in_req = r;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    pending_poses.push_back(predict_pose(r, dt_shadow));
  endtask

  // Lowers start for a number of cycles while the request bus carries junk.
  task automatic idle_cycles(input int n);
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      start = 1'b0;
      in_req = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end
  endtask

  // Mostly back-to-back, some short gaps, a few long ones.
  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      idle_cycles($urandom_range(15, 60));
    end else if (pick < 40) begin
      idle_cycles($urandom_range(1, 4));
    end
  endtask

  // Waits for the pipeline to empty, then rewrites the time step.
  task automatic write_step_time(input logic [upp_pkg::DT_W-1:0] value);
    idle_cycles(1);
    wait (pending_poses.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = upp_pkg::DT_W'($urandom);
    dt_shadow = value;
  endtask

  function automatic upp_pkg::in_req_t make_pose(input int px, input int py, input int hd,
                                                 input int v, input int w);
    upp_pkg::in_req_t r;
    r.pos_x = px;
    r.pos_y = py;
    r.heading = hd;
    r.cmd_speed = v;
    r.cmd_turn_rate = w;
    return r;
  endfunction

  // A pose such as a filter would hold: modest position, speed and turn rate,
  // with the heading anywhere in a few turns.
  function automatic upp_pkg::in_req_t plausible_pose();
    upp_pkg::in_req_t r;
    r.pos_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    r.pos_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    r.heading = $signed($urandom_range(0, 8 * PI_Q16)) - 4 * PI_Q16;
    r.cmd_speed = $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
    r.cmd_turn_rate = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    return r;
  endfunction

  // Extremes of every field, headings on the quadrant edges and saturating sums.
  task automatic test_edge_poses();
    int hd_list[12];
    hd_list = '{0, HALF_PI_Q16, -HALF_PI_Q16, HALF_PI_Q16 + 1, PI_Q16, -PI_Q16,
                PI_Q16 - 1, 2 * PI_Q16, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1};
    foreach (hd_list[i]) send_request(make_pose(0, 0, hd_list[i], 32'h0001_0000, 0));
    send_request(make_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF));
    send_request(make_pose(32'sh8000_0000, 32'sh8000_0000, PI_Q16, 32'sh7FFF_FFFF,
                           32'sh8000_0000));
    send_request(make_pose(32'sh7FFF_FFFF, 32'sh8000_0000, -HALF_PI_Q16,
                           32'sh8000_0000, 32'sh8000_0000));
    send_request(make_pose(32'sh8000_0000, 32'sh7FFF_FFFF, HALF_PI_Q16,
                           32'sh8000_0000, 32'sh7FFF_FFFF));
    send_request(make_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
    idle_cycles(1);
  endtask

  // Runs the edge poses at the extreme and a few ordinary time steps.
  task automatic test_step_time_sweep();
    logic [upp_pkg::DT_W-1:0] steps[5];
    steps = '{24'd0, 24'hFF_FFFF, 24'd1, 24'h01_0000, upp_pkg::STEP_TIME_RST};
    foreach (steps[i]) begin
      write_step_time(steps[i]);
      test_edge_poses();
    end
  endtask

  // Random requests with random gaps; the time step changes every so often.
  task automatic test_random_poses(input int count);
    upp_pkg::in_req_t r;
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 199) write_step_time(upp_pkg::DT_W'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        r = plausible_pose();
      end
      send_request(r);
      random_gap();
    end
    idle_cycles(1);
  endtask

  initial begin
    fail_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    dt_shadow = upp_pkg::STEP_TIME_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The reset value of the time step is checked before any write.
    test_edge_poses();
    test_step_time_sweep();
    test_random_poses(1000);

    wait (pending_poses.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guards against a hung pipeline; the slowest run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
